// ===== design/crt_pkg.sv =====
// Shared types, constants and command codes for the CRT solver.
// No dependencies; used by crt_ctrl, crt_dp and crt_solver_core.
package crt_pkg;

	localparam int MAX_CONG = 4;
	localparam int MOD_BITS = 15;
	localparam int SOL_BITS = 60;
	localparam int IDX_W    = $clog2(MAX_CONG);
	localparam int CNT_W    = $clog2(MAX_CONG + 1);
	localparam int DCNT_W   = $clog2(SOL_BITS + 1);
	localparam int MCNT_W   = $clog2(MOD_BITS + 1);
	localparam int COEF_W   = MOD_BITS + 2;
	localparam int PROD_W   = 2 * MOD_BITS + 2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_COPRIME  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [MOD_BITS-1:0] residue;
		logic [MOD_BITS-1:0] modulus;
		logic                last;
	} in_item_t;

	typedef struct packed {
		logic [SOL_BITS-1:0] solution;
		logic [1:0]          status;
	} out_item_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_STORE,
		CMD_INIT_N,
		CMD_MUL_N,
		CMD_TAKE_N,
		CMD_INIT_E,
		CMD_DIV_N,
		CMD_DIV_R,
		CMD_EUC_INIT,
		CMD_DIV_Q,
		CMD_EUC_MUL,
		CMD_EUC_UPD,
		CMD_MUL_T1,
		CMD_DIV_T,
		CMD_MUL_T2,
		CMD_ACC,
		CMD_OUT
	} cmd_t;

	typedef struct packed {
		cmd_t       op;
		logic [1:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic ovf;
		logic mod_zero;
		logic last_idx;
		logic r1_zero;
		logic r0_one;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHK,
		S_NLOOP,
		S_NMUL,
		S_EINIT,
		S_ESTART,
		S_EDIV1,
		S_EDIV2,
		S_EUC,
		S_EUC_DIV,
		S_EUC_MUL,
		S_EUC_UPD,
		S_INV,
		S_TMUL1,
		S_TDIV,
		S_TMUL2,
		S_FIN
	} state_t;

endpackage

// ===== design/crt_solver_core.sv =====
// CRT solver top level. Non-last items are taken one per cycle while idle.
// A last item starts a solve over the E stored entries, run on the bit-serial
// divider and the shift-add multiplier with a Euclid loop per entry; no new item
// is taken meanwhile.
// Reset (arst_n low, asynchronous) empties the store and drops any result.
// Depends on crt_pkg, crt_ctrl and crt_dp.
module crt_solver_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  crt_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output crt_pkg::out_item_t result
);

	crt_pkg::dp_cmd_t  cmd;
	crt_pkg::dp_stat_t stat;

	crt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_last    (item.last),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	crt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

// ===== design/crt_dp.sv =====
// Datapath of the CRT solver: congruence store, shared restoring divider,
// shift-add multiplier, Euclid registers and output register. Uses crt_pkg.
module crt_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  crt_pkg::in_item_t  item,
	input  crt_pkg::dp_cmd_t   cmd,
	output crt_pkg::dp_stat_t  stat,
	output crt_pkg::out_item_t result
);

	logic [crt_pkg::MOD_BITS-1:0] res_q [crt_pkg::MAX_CONG];
	logic [crt_pkg::MOD_BITS-1:0] mod_q [crt_pkg::MAX_CONG];
	logic [crt_pkg::CNT_W-1:0]    cnt_q;
	logic                         ovf_q;
	logic [crt_pkg::IDX_W-1:0]    idx_q;

	logic [crt_pkg::SOL_BITS-1:0] bign_q, n_q, acc_q;
	logic [crt_pkg::MOD_BITS-1:0] m_q, r0_q, r1_q, rt_q;
	logic signed [crt_pkg::COEF_W-1:0] s0_q, s1_q;
	logic signed [crt_pkg::PROD_W-1:0] prod_q;

	// divider
	logic [crt_pkg::SOL_BITS-1:0] dvd_q, quo_q;
	logic [crt_pkg::MOD_BITS-1:0] dvs_q, rem_q;
	logic [crt_pkg::DCNT_W-1:0]   dcnt_q;
	logic [crt_pkg::MOD_BITS:0]   rem_sh, rem_nx;
	logic                         qbit;

	// multiplier
	logic [crt_pkg::SOL_BITS-1:0] mcand_q, mprod_q;
	logic [crt_pkg::MOD_BITS-1:0] mplier_q;
	logic [crt_pkg::MCNT_W-1:0]   mcnt_q;

	logic [crt_pkg::MOD_BITS-1:0] cur_mod;
	logic [crt_pkg::MOD_BITS-1:0] inv;
	logic signed [crt_pkg::COEF_W-1:0] s_adj;
	logic [crt_pkg::SOL_BITS:0]   sum;
	logic [crt_pkg::SOL_BITS:0]   sum_red;

	always_comb begin
		cur_mod = mod_q[idx_q];
		rem_sh  = {rem_q, dvd_q[crt_pkg::SOL_BITS-1]};
		qbit    = (rem_sh >= {1'b0, dvs_q});
		rem_nx  = qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
		// fold the Bezout coefficient into 0..m-1
		s_adj = (s0_q < 0) ? (s0_q + $signed({2'b00, m_q})) : s0_q;
		if (s_adj >= $signed({2'b00, m_q})) begin
			s_adj = s_adj - $signed({2'b00, m_q});
		end
		inv     = s_adj[crt_pkg::MOD_BITS-1:0];
		sum     = {1'b0, acc_q} + {1'b0, mprod_q};
		sum_red = (sum >= {1'b0, bign_q}) ? (sum - {1'b0, bign_q}) : sum;
	end

	always_comb begin
		stat.busy     = (dcnt_q != '0) || (mcnt_q != '0);
		stat.ovf      = ovf_q;
		stat.mod_zero = (cur_mod == '0);
		stat.last_idx = ({1'b0, idx_q} + crt_pkg::CNT_W'(1)) == cnt_q;
		stat.r1_zero  = (r1_q == '0);
		stat.r0_one   = (r0_q == crt_pkg::MOD_BITS'(1));
	end

	// control state of the store and the divider and multiplier step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			dcnt_q <= '0;
			mcnt_q <= '0;
		end else begin
			if (cmd.op == crt_pkg::CMD_STORE) begin
				if (cnt_q < crt_pkg::CNT_W'(crt_pkg::MAX_CONG)) begin
					cnt_q <= cnt_q + crt_pkg::CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end else if (cmd.op == crt_pkg::CMD_OUT) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			case (cmd.op)
				crt_pkg::CMD_DIV_N, crt_pkg::CMD_DIV_R, crt_pkg::CMD_DIV_T: begin
					dcnt_q <= crt_pkg::DCNT_W'(crt_pkg::SOL_BITS);
				end
				crt_pkg::CMD_DIV_Q: begin
					dcnt_q <= crt_pkg::DCNT_W'(crt_pkg::MOD_BITS);
				end
				default: begin
					if (dcnt_q != '0) begin
						dcnt_q <= dcnt_q - crt_pkg::DCNT_W'(1);
					end
				end
			endcase
			case (cmd.op)
				crt_pkg::CMD_MUL_N, crt_pkg::CMD_MUL_T1, crt_pkg::CMD_MUL_T2: begin
					mcnt_q <= crt_pkg::MCNT_W'(crt_pkg::MOD_BITS);
				end
				default: begin
					if (mcnt_q != '0) begin
						mcnt_q <= mcnt_q - crt_pkg::MCNT_W'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == crt_pkg::CMD_STORE && cnt_q < crt_pkg::CNT_W'(crt_pkg::MAX_CONG)) begin
			res_q[cnt_q[crt_pkg::IDX_W-1:0]] <= item.residue;
			mod_q[cnt_q[crt_pkg::IDX_W-1:0]] <= item.modulus;
		end

		// divider step
		if (dcnt_q != '0) begin
			rem_q <= rem_nx[crt_pkg::MOD_BITS-1:0];
			dvd_q <= {dvd_q[crt_pkg::SOL_BITS-2:0], 1'b0};
			quo_q <= {quo_q[crt_pkg::SOL_BITS-2:0], qbit};
		end
		// multiplier step
		if (mcnt_q != '0) begin
			if (mplier_q[0]) begin
				mprod_q <= mprod_q + mcand_q;
			end
			mcand_q  <= {mcand_q[crt_pkg::SOL_BITS-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[crt_pkg::MOD_BITS-1:1]};
		end

		case (cmd.op)
			crt_pkg::CMD_INIT_N: begin
				bign_q <= crt_pkg::SOL_BITS'(1);
				idx_q  <= '0;
			end
			crt_pkg::CMD_MUL_N: begin
				mcand_q  <= bign_q;
				mplier_q <= cur_mod;
				mprod_q  <= '0;
			end
			crt_pkg::CMD_TAKE_N: begin
				bign_q <= mprod_q;
				idx_q  <= idx_q + crt_pkg::IDX_W'(1);
			end
			crt_pkg::CMD_INIT_E: begin
				idx_q <= '0;
				acc_q <= '0;
			end
			crt_pkg::CMD_DIV_N: begin
				m_q   <= cur_mod;
				dvs_q <= cur_mod;
				dvd_q <= bign_q;
				rem_q <= '0;
				quo_q <= '0;
			end
			crt_pkg::CMD_DIV_R: begin
				n_q   <= quo_q;
				dvd_q <= quo_q;
				rem_q <= '0;
				quo_q <= '0;
			end
			crt_pkg::CMD_EUC_INIT: begin
				r0_q <= rem_q;
				r1_q <= m_q;
				s0_q <= crt_pkg::COEF_W'(1);
				s1_q <= '0;
			end
			crt_pkg::CMD_DIV_Q: begin
				dvs_q <= r1_q;
				dvd_q <= {r0_q, (crt_pkg::SOL_BITS - crt_pkg::MOD_BITS)'(0)};
				rem_q <= '0;
				quo_q <= '0;
			end
			crt_pkg::CMD_EUC_MUL: begin
				rt_q   <= rem_q;
				prod_q <= crt_pkg::PROD_W'($signed({1'b0, quo_q[crt_pkg::MOD_BITS-1:0]}) * s1_q);
			end
			crt_pkg::CMD_EUC_UPD: begin
				r0_q <= r1_q;
				r1_q <= rt_q;
				s0_q <= s1_q;
				s1_q <= crt_pkg::COEF_W'($signed({{(crt_pkg::PROD_W-crt_pkg::COEF_W){s0_q[crt_pkg::COEF_W-1]}}, s0_q}) - prod_q);
			end
			crt_pkg::CMD_MUL_T1: begin
				mcand_q  <= crt_pkg::SOL_BITS'(res_q[idx_q]);
				mplier_q <= inv;
				mprod_q  <= '0;
			end
			crt_pkg::CMD_DIV_T: begin
				dvs_q <= m_q;
				dvd_q <= mprod_q;
				rem_q <= '0;
				quo_q <= '0;
			end
			crt_pkg::CMD_MUL_T2: begin
				mcand_q  <= n_q;
				mplier_q <= rem_q;
				mprod_q  <= '0;
			end
			crt_pkg::CMD_ACC: begin
				acc_q <= sum_red[crt_pkg::SOL_BITS-1:0];
				idx_q <= idx_q + crt_pkg::IDX_W'(1);
			end
			crt_pkg::CMD_OUT: begin
				result.status   <= cmd.code;
				result.solution <= (cmd.code == crt_pkg::ST_OK) ? acc_q : '0;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/crt_ctrl.sv =====
// Controller of the CRT solver: sequences load, product, per-entry inverse
// and accumulation steps; owns the handshakes. Uses crt_pkg types.
module crt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_last,
	output logic              item_stall,
	output logic              result_valid,
	input  logic              result_stall,
	input  crt_pkg::dp_stat_t stat,
	output crt_pkg::dp_cmd_t  cmd
);

	crt_pkg::state_t state_q, state_nx;
	logic [1:0]      code_q, code_nx;
	logic            valid_q;
	logic            load;

	assign item_stall   = (state_q != crt_pkg::S_IDLE);
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crt_pkg::S_IDLE;
			code_q  <= crt_pkg::ST_OK;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			code_q  <= code_nx;
			if (load) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		code_nx  = code_q;
		cmd.op   = crt_pkg::CMD_NONE;
		cmd.code = code_q;
		load     = 1'b0;
		case (state_q)
			crt_pkg::S_IDLE: begin
				if (item_valid) begin
					cmd.op = crt_pkg::CMD_STORE;
					if (item_last) begin
						state_nx = crt_pkg::S_CHK;
					end
				end
			end
			crt_pkg::S_CHK: begin
				if (stat.ovf) begin
					code_nx  = crt_pkg::ST_OVERFLOW;
					state_nx = crt_pkg::S_FIN;
				end else begin
					cmd.op   = crt_pkg::CMD_INIT_N;
					state_nx = crt_pkg::S_NLOOP;
				end
			end
			crt_pkg::S_NLOOP: begin
				if (stat.mod_zero) begin
					code_nx  = crt_pkg::ST_COPRIME;
					state_nx = crt_pkg::S_FIN;
				end else begin
					cmd.op   = crt_pkg::CMD_MUL_N;
					state_nx = crt_pkg::S_NMUL;
				end
			end
			crt_pkg::S_NMUL: begin
				if (!stat.busy) begin
					cmd.op   = crt_pkg::CMD_TAKE_N;
					state_nx = stat.last_idx ? crt_pkg::S_EINIT : crt_pkg::S_NLOOP;
				end
			end
			crt_pkg::S_EINIT: begin
				cmd.op   = crt_pkg::CMD_INIT_E;
				state_nx = crt_pkg::S_ESTART;
			end
			crt_pkg::S_ESTART: begin
				cmd.op   = crt_pkg::CMD_DIV_N;
				state_nx = crt_pkg::S_EDIV1;
			end
			crt_pkg::S_EDIV1: begin
				if (!stat.busy) begin
					cmd.op   = crt_pkg::CMD_DIV_R;
					state_nx = crt_pkg::S_EDIV2;
				end
			end
			crt_pkg::S_EDIV2: begin
				if (!stat.busy) begin
					cmd.op   = crt_pkg::CMD_EUC_INIT;
					state_nx = crt_pkg::S_EUC;
				end
			end
			crt_pkg::S_EUC: begin
				if (stat.r1_zero) begin
					state_nx = crt_pkg::S_INV;
				end else begin
					cmd.op   = crt_pkg::CMD_DIV_Q;
					state_nx = crt_pkg::S_EUC_DIV;
				end
			end
			crt_pkg::S_EUC_DIV: begin
				if (!stat.busy) begin
					cmd.op   = crt_pkg::CMD_EUC_MUL;
					state_nx = crt_pkg::S_EUC_UPD;
				end
			end
			crt_pkg::S_EUC_MUL: begin
				state_nx = crt_pkg::S_EUC_UPD;
			end
			crt_pkg::S_EUC_UPD: begin
				cmd.op   = crt_pkg::CMD_EUC_UPD;
				state_nx = crt_pkg::S_EUC;
			end
			crt_pkg::S_INV: begin
				if (!stat.r0_one) begin
					code_nx  = crt_pkg::ST_COPRIME;
					state_nx = crt_pkg::S_FIN;
				end else begin
					cmd.op   = crt_pkg::CMD_MUL_T1;
					state_nx = crt_pkg::S_TMUL1;
				end
			end
			crt_pkg::S_TMUL1: begin
				if (!stat.busy) begin
					cmd.op   = crt_pkg::CMD_DIV_T;
					state_nx = crt_pkg::S_TDIV;
				end
			end
			crt_pkg::S_TDIV: begin
				if (!stat.busy) begin
					cmd.op   = crt_pkg::CMD_MUL_T2;
					state_nx = crt_pkg::S_TMUL2;
				end
			end
			crt_pkg::S_TMUL2: begin
				if (!stat.busy) begin
					cmd.op = crt_pkg::CMD_ACC;
					if (stat.last_idx) begin
						code_nx  = crt_pkg::ST_OK;
						state_nx = crt_pkg::S_FIN;
					end else begin
						state_nx = crt_pkg::S_ESTART;
					end
				end
			end
			crt_pkg::S_FIN: begin
				// hold until the output register is free
				if (!valid_q || !result_stall) begin
					cmd.op   = crt_pkg::CMD_OUT;
					load     = 1'b1;
					state_nx = crt_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = crt_pkg::S_IDLE;
			end
		endcase
	end

endmodule
